/* src/assert_macros.svh */
// assertion macros shared by the cipher rtl
// no dependencies; expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define ASSERT_NXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

/* src/rbc_pkg.sv */
// types, constants and round functions of the rotated camellia-128 decryptor
// no dependencies
`default_nettype none

package rbc_pkg;

    typedef struct packed {
        logic [31:0] block_address;
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
        logic        last_in;
    } in_item_t;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
        logic        last_out;
    } out_item_t;

    typedef enum logic [1:0] {
        REG_KEY_HIGH       = 2'd0,
        REG_KEY_LOW        = 2'd1,
        REG_ARCHIVE_BASE   = 2'd2,
        REG_DECRYPT_ENABLE = 2'd3
    } cfg_reg_t;

    localparam logic [3:0] ROT_MASK = 4'hf;
    localparam int ROT_BASE = 16;
    localparam int KEY_BITS = 128;

    localparam int SK_KW = 0;
    localparam int SK_K  = 4;
    localparam int SK_KE = 22;

    localparam logic [63:0] SIGMA1 = 64'hA09E667F3BCC908B;
    localparam logic [63:0] SIGMA2 = 64'hB67AE8584CAA73B2;
    localparam logic [63:0] SIGMA3 = 64'hC6EF372FE94F82BE;
    localparam logic [63:0] SIGMA4 = 64'h54FF53A5F1D36F1C;

    localparam logic [7:0] SBOX [256] = '{
        112,130, 44,236,179, 39,192,229,228,133, 87, 53,234, 12,174, 65,
         35,239,107,147, 69, 25,165, 33,237, 14, 79, 78, 29,101,146,189,
        134,184,175,143,124,235, 31,206, 62, 48,220, 95, 94,197, 11, 26,
        166,225, 57,202,213, 71, 93, 61,217,  1, 90,214, 81, 86,108, 77,
        139, 13,154,102,251,204,176, 45,116, 18, 43, 32,240,177,132,153,
        223, 76,203,194, 52,126,118,  5,109,183,169, 49,209, 23,  4,215,
         20, 88, 58, 97,222, 27, 17, 28, 50, 15,156, 22, 83, 24,242, 34,
        254, 68,207,178,195,181,122,145, 36,  8,232,168, 96,252,105, 80,
        170,208,160,125,161,137, 98,151, 84, 91, 30,149,224,255,100,210,
         16,196,  0, 72,163,247,117,219,138,  3,230,218,  9, 63,221,148,
        135, 92,131,  2,205, 74,144, 51,115,103,246,243,157,127,191,226,
         82,155,216, 38,200, 55,198, 59,129,150,111, 75, 19,190, 99, 46,
        233,121,167,140,159,110,188,142, 41,245,249,182, 47,253,180, 89,
        120,152,  6,106,231, 70,113,186,212, 37,171, 66,136,162,141,250,
        114,  7,185, 85,248,238,172, 10, 54, 73, 42,104, 60, 56,241,164,
         64, 40,211,123,187,201, 67,193, 21,227,173,244,119,199,128,158
    };

    function automatic logic [7:0] s_a(logic [7:0] x);
        return SBOX[x];
    endfunction

    function automatic logic [7:0] s_b(logic [7:0] x);
        logic [7:0] v;
        v = SBOX[x];
        return {v[6:0], v[7]};
    endfunction

    function automatic logic [7:0] s_c(logic [7:0] x);
        logic [7:0] v;
        v = SBOX[x];
        return {v[0], v[7:1]};
    endfunction

    function automatic logic [7:0] s_d(logic [7:0] x);
        return SBOX[{x[6:0], x[7]}];
    endfunction

    function automatic logic [63:0] feistel(logic [63:0] din, logic [63:0] k);
        logic [63:0] x;
        logic [7:0] t1, t2, t3, t4, t5, t6, t7, t8;
        x  = din ^ k;
        t1 = s_a(x[63:56]);
        t2 = s_b(x[55:48]);
        t3 = s_c(x[47:40]);
        t4 = s_d(x[39:32]);
        t5 = s_b(x[31:24]);
        t6 = s_c(x[23:16]);
        t7 = s_d(x[15:8]);
        t8 = s_a(x[7:0]);
        return {t1 ^ t3 ^ t4 ^ t6 ^ t7 ^ t8,
                t1 ^ t2 ^ t4 ^ t5 ^ t7 ^ t8,
                t1 ^ t2 ^ t3 ^ t5 ^ t6 ^ t8,
                t2 ^ t3 ^ t4 ^ t5 ^ t6 ^ t7,
                t1 ^ t2 ^ t6 ^ t7 ^ t8,
                t2 ^ t3 ^ t5 ^ t7 ^ t8,
                t3 ^ t4 ^ t5 ^ t6 ^ t8,
                t1 ^ t4 ^ t5 ^ t6 ^ t7};
    endfunction

    function automatic logic [63:0] fl_fwd(logic [63:0] x, logic [63:0] k);
        logic [31:0] x1, x2, a;
        x1 = x[63:32];
        x2 = x[31:0];
        a  = x1 & k[63:32];
        x2 = x2 ^ {a[30:0], a[31]};
        x1 = x1 ^ (x2 | k[31:0]);
        return {x1, x2};
    endfunction

    function automatic logic [63:0] fl_inv(logic [63:0] y, logic [63:0] k);
        logic [31:0] y1, y2, a;
        y1 = y[63:32];
        y2 = y[31:0];
        y1 = y1 ^ (y2 | k[31:0]);
        a  = y1 & k[63:32];
        y2 = y2 ^ {a[30:0], a[31]};
        return {y1, y2};
    endfunction

    // rotate by a constant amount, pure wiring
    function automatic logic [KEY_BITS-1:0] rot128(logic [KEY_BITS-1:0] v, int n);
        return (v << n) | (v >> (KEY_BITS - n));
    endfunction

    // subkey by table position, from kl and ka
    function automatic logic [63:0] subkey(logic [KEY_BITS-1:0] kl,
                                           logic [KEY_BITS-1:0] ka, int idx);
        logic [63:0] r;
        case (idx)
            SK_KW + 0: r = kl[127:64];
            SK_KW + 1: r = kl[63:0];
            SK_KW + 2: r = 64'(rot128(ka, 111) >> 64);
            SK_KW + 3: r = 64'(rot128(ka, 111));
            SK_K + 0:  r = ka[127:64];
            SK_K + 1:  r = ka[63:0];
            SK_K + 2:  r = 64'(rot128(kl, 15) >> 64);
            SK_K + 3:  r = 64'(rot128(kl, 15));
            SK_K + 4:  r = 64'(rot128(ka, 15) >> 64);
            SK_K + 5:  r = 64'(rot128(ka, 15));
            SK_K + 6:  r = 64'(rot128(kl, 45) >> 64);
            SK_K + 7:  r = 64'(rot128(kl, 45));
            SK_K + 8:  r = 64'(rot128(ka, 45) >> 64);
            SK_K + 9:  r = 64'(rot128(kl, 60));
            SK_K + 10: r = 64'(rot128(ka, 60) >> 64);
            SK_K + 11: r = 64'(rot128(ka, 60));
            SK_K + 12: r = 64'(rot128(kl, 94) >> 64);
            SK_K + 13: r = 64'(rot128(kl, 94));
            SK_K + 14: r = 64'(rot128(ka, 94) >> 64);
            SK_K + 15: r = 64'(rot128(ka, 94));
            SK_K + 16: r = 64'(rot128(kl, 111) >> 64);
            SK_K + 17: r = 64'(rot128(kl, 111));
            SK_KE + 0: r = 64'(rot128(ka, 30) >> 64);
            SK_KE + 1: r = 64'(rot128(ka, 30));
            SK_KE + 2: r = 64'(rot128(kl, 77) >> 64);
            SK_KE + 3: r = 64'(rot128(kl, 77));
            default:   r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/rbc_keysched.sv */
// key schedule sequencer: derives ka from the key over four feistel steps
// depends on rbc_pkg
`default_nettype none

module rbc_keysched (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [rbc_pkg::KEY_BITS-1:0] key,
    output logic      [rbc_pkg::KEY_BITS-1:0] ka,
    output logic                              busy
);

    typedef enum logic [2:0] {KS_LOAD, KS_F1, KS_F2, KS_F3, KS_F4, KS_DONE} ks_state_t;

    ks_state_t   state_reg;
    logic [63:0] d1_reg, d2_reg;
    logic [63:0] f_in, f_key, f_out;

    always_comb
    begin
        f_in  = d2_reg;
        f_key = rbc_pkg::SIGMA2;
        case (state_reg)
            KS_F1:   begin f_in = d1_reg; f_key = rbc_pkg::SIGMA1; end
            KS_F2:   begin f_in = d2_reg; f_key = rbc_pkg::SIGMA2; end
            KS_F3:   begin f_in = d1_reg; f_key = rbc_pkg::SIGMA3; end
            KS_F4:   begin f_in = d2_reg; f_key = rbc_pkg::SIGMA4; end
            default: begin f_in = d2_reg; f_key = rbc_pkg::SIGMA2; end
        endcase
        f_out = rbc_pkg::feistel(f_in, f_key);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= KS_LOAD;
        end
        else if (start)
        begin
            state_reg <= KS_LOAD;
        end
        else
        begin
            case (state_reg)
                KS_LOAD:
                begin
                    d1_reg    <= key[127:64];
                    d2_reg    <= key[63:0];
                    state_reg <= KS_F1;
                end
                KS_F1:
                begin
                    d2_reg    <= d2_reg ^ f_out;
                    state_reg <= KS_F2;
                end
                KS_F2:
                begin
                    // second sigma round folds in the key again
                    d1_reg    <= d1_reg ^ f_out ^ key[127:64];
                    d2_reg    <= d2_reg ^ key[63:0];
                    state_reg <= KS_F3;
                end
                KS_F3:
                begin
                    d2_reg    <= d2_reg ^ f_out;
                    state_reg <= KS_F4;
                end
                KS_F4:
                begin
                    d1_reg    <= d1_reg ^ f_out;
                    state_reg <= KS_DONE;
                end
                default:
                begin
                    state_reg <= KS_DONE;
                end
            endcase
        end
    end

    assign ka   = {d1_reg, d2_reg};
    assign busy = (state_reg != KS_DONE);

endmodule

`default_nettype wire

/* src/rotated_block_cipher_decrypt.sv */
// one block per cycle while neither a stalled output nor key derivation holds the input;
// one feistel round per round stage (entry stage plus 18 round stages)
// the whole pipeline holds while a waiting output is stalled
// reset and every key write start the subkey derivation, input stalled meanwhile
// reset clears the config registers to zero and empties the pipeline
`default_nettype none
`include "assert_macros.svh"

module rotated_block_cipher_decrypt (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire rbc_pkg::in_item_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output rbc_pkg::out_item_t     out_data,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [63:0]       cfg_data
);

    localparam int ROUNDS = 18;
    localparam int NST    = ROUNDS + 1;

    logic [63:0] key_high_reg, key_low_reg;
    logic [31:0] archive_base_reg;
    logic        decrypt_enable_reg;

    logic [rbc_pkg::KEY_BITS-1:0] kl, ka;
    logic key_start, ks_busy;

    logic [63:0] d1_reg [NST];
    logic [63:0] d2_reg [NST];
    logic        last_reg [NST];
    logic        valid_reg [NST];
    logic [63:0] d1_next [NST];
    logic [63:0] d2_next [NST];

    logic advance, in_xfer;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg       <= '0;
            key_low_reg        <= '0;
            archive_base_reg   <= '0;
            decrypt_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rbc_pkg::REG_KEY_HIGH:       key_high_reg       <= cfg_data;
                rbc_pkg::REG_KEY_LOW:        key_low_reg        <= cfg_data;
                rbc_pkg::REG_ARCHIVE_BASE:   archive_base_reg   <= cfg_data[31:0];
                rbc_pkg::REG_DECRYPT_ENABLE: decrypt_enable_reg <= cfg_data[0];
                default:                     decrypt_enable_reg <= decrypt_enable_reg;
            endcase
        end
    end

    assign key_start = cfg_we && (cfg_index == rbc_pkg::REG_KEY_HIGH
                                  || cfg_index == rbc_pkg::REG_KEY_LOW);
    assign kl = {key_high_reg, key_low_reg};

    rbc_keysched u_keysched (
        .clk   (clk),
        .rst_n (rst_n),
        .start (key_start),
        .key   (kl),
        .ka    (ka),
        .busy  (ks_busy)
    );

    assign advance  = !valid_reg[NST-1] || !out_stall;
    assign in_stall = !advance || ks_busy;
    assign in_xfer  = in_valid && !in_stall;

    function automatic logic [31:0] bswap32(logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic [31:0] rol32(logic [31:0] w, logic [5:0] n);
        logic [63:0] t;
        t = {w, w} << n;
        return t[63:32];
    endfunction

    // entry stage: word rotation and input whitening when decryption is enabled, else pass-through
    always_comb
    begin
        logic [31:0] sum;
        logic [5:0]  sl, sr;
        sum = archive_base_reg + in_data.block_address;
        sl  = 6'(rbc_pkg::ROT_BASE) + {2'b00, sum[7:4] & rbc_pkg::ROT_MASK};
        sr  = 6'd32 - sl;
        if (decrypt_enable_reg)
        begin
            d1_next[0] = {bswap32(rol32(bswap32(in_data.cipher_high[63:32]), sl)),
                          bswap32(rol32(bswap32(in_data.cipher_high[31:0]), sr))}
                         ^ rbc_pkg::subkey(kl, ka, rbc_pkg::SK_KW + 2);
            d2_next[0] = {bswap32(rol32(bswap32(in_data.cipher_low[63:32]), sl)),
                          bswap32(rol32(bswap32(in_data.cipher_low[31:0]), sr))}
                         ^ rbc_pkg::subkey(kl, ka, rbc_pkg::SK_KW + 3);
        end
        else
        begin
            d1_next[0] = in_data.cipher_high;
            d2_next[0] = in_data.cipher_low;
        end
    end

    // stage j+1 runs round j; fl layers follow rounds 5 and 11; all pass-through when decryption is disabled
    for (genvar j = 0; j < ROUNDS; j++)
    begin : g_round
        always_comb
        begin
            logic [63:0] a, b;
            a = d1_reg[j];
            b = d2_reg[j];
            if (decrypt_enable_reg)
            begin
                if (j % 2 == 0)
                    b = b ^ rbc_pkg::feistel(a, rbc_pkg::subkey(kl, ka, rbc_pkg::SK_K + 17 - j));
                else
                    a = a ^ rbc_pkg::feistel(b, rbc_pkg::subkey(kl, ka, rbc_pkg::SK_K + 17 - j));
                if (j == 5)
                begin
                    a = rbc_pkg::fl_fwd(a, rbc_pkg::subkey(kl, ka, rbc_pkg::SK_KE + 3));
                    b = rbc_pkg::fl_inv(b, rbc_pkg::subkey(kl, ka, rbc_pkg::SK_KE + 2));
                end
                else if (j == 11)
                begin
                    a = rbc_pkg::fl_fwd(a, rbc_pkg::subkey(kl, ka, rbc_pkg::SK_KE + 1));
                    b = rbc_pkg::fl_inv(b, rbc_pkg::subkey(kl, ka, rbc_pkg::SK_KE + 0));
                end
            end
            d1_next[j+1] = a;
            d2_next[j+1] = b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int i = 0; i < NST; i++)
            begin
                d1_reg[i] <= d1_next[i];
                d2_reg[i] <= d2_next[i];
            end
            last_reg[0] <= in_data.last_in;
            for (int i = 1; i < NST; i++)
                last_reg[i] <= last_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
                valid_reg[i] <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= in_xfer;
            for (int i = 1; i < NST; i++)
                valid_reg[i] <= valid_reg[i-1];
        end
    end

    // exit whitening, halves swap back; pass-through with no swap when decryption is disabled
    always_comb
    begin
        if (decrypt_enable_reg)
        begin
            out_data.plain_high = d2_reg[NST-1] ^ rbc_pkg::subkey(kl, ka, rbc_pkg::SK_KW + 0);
            out_data.plain_low  = d1_reg[NST-1] ^ rbc_pkg::subkey(kl, ka, rbc_pkg::SK_KW + 1);
        end
        else
        begin
            out_data.plain_high = d1_reg[NST-1];
            out_data.plain_low  = d2_reg[NST-1];
        end
        out_data.last_out = last_reg[NST-1];
    end

    assign out_valid = valid_reg[NST-1];

    `ASSERT_IMP(a_busy_stalls, ks_busy, in_stall, "input taken during key derivation")
    `ASSERT_NXT(a_key_busy, key_start, ks_busy, "key write did not start derivation")
    `ASSERT_NXT(a_hold_entry, !advance, $stable(valid_reg[0]), "entry stage moved while held")

endmodule

`default_nettype wire
